### rtl/voice_activity_detector_defines.svh
// ----------------------------------------------------------------------------
// Voice activity detector assertion macros
// Shared concurrent assertion forms for the detector RTL.
// ----------------------------------------------------------------------------
`ifndef VOICE_ACTIVITY_DETECTOR_DEFINES_SVH
`define VOICE_ACTIVITY_DETECTOR_DEFINES_SVH

// Flag a condition that must never hold outside reset
`define VAD_ASSERT_NEVER(name, clk, rst, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

// Flag a consequent that fails to follow its antecedent in the same cycle
`define VAD_ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/vad_pkg.sv
// ----------------------------------------------------------------------------
// Voice activity detector package
// Widths, register indexes, reset values and shared types of the detector.
// ----------------------------------------------------------------------------
`default_nettype none

package vad_pkg;

  // Packet length limit, in samples
  localparam int unsigned MAX_SAMPLES = 4096;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned VOL_W      = 16;
  localparam int unsigned THRESH_W   = 16;
  localparam int unsigned RUN_W      = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  // Sample count holds MAX_SAMPLES itself; the sum holds MAX_SAMPLES * 2^15
  localparam int unsigned COUNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W   = COUNT_W + SAMPLE_W - 1;
  localparam int unsigned ITER_W  = $clog2(SUM_W);

  // Queue of closed packets between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [RUN_W-1:0]    RUN_MAX        = '1;
  localparam logic [THRESH_W-1:0] THRESH_RESET   = 16'd2000;
  localparam logic [RUN_W-1:0]    SPEAKING_RESET = 8'd6;
  localparam logic [RUN_W-1:0]    SILENCE_RESET  = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOLUME_THRESHOLD = 2'd0,
    REG_SPEAKING_RUN     = 2'd1,
    REG_SILENCE_RUN      = 2'd2
  } reg_index_t;

  // One closed packet waiting for its division
  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] count;
    logic               forced;
  } close_t;

  typedef struct packed {
    logic [THRESH_W-1:0] threshold;
    logic [RUN_W-1:0]    speaking_run;
    logic [RUN_W-1:0]    silence_run;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Saturating run increment
  function automatic logic [RUN_W-1:0] run_bump(input logic [RUN_W-1:0] r);
    run_bump = (r == RUN_MAX) ? RUN_MAX : r + 1'b1;
  endfunction

endpackage

`default_nettype wire

### rtl/vad_front.sv
// ----------------------------------------------------------------------------
// Voice activity detector front end
// Accumulates sample magnitudes and closes packets into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module vad_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 q_full,
  input  logic signed [vad_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                 last_sample,
  output logic                                 push,
  output vad_pkg::close_t                      entry
);
  import vad_pkg::*;

  logic [SUM_W-1:0]    sum;
  logic [COUNT_W-1:0]  count;
  logic [SUM_W-1:0]    sum_next;
  logic [COUNT_W-1:0]  count_next;
  logic [SAMPLE_W-1:0] mag;
  logic                accept;
  logic                at_limit;
  logic                closing;

  // Take a magnitude: the most negative sample gives 0x8000
  always_comb begin
    mag        = sample[SAMPLE_W-1] ? (~$unsigned(sample) + 1'b1) : $unsigned(sample);
    accept     = in_valid && !q_full;
    sum_next   = sum + SUM_W'(mag);
    count_next = count + 1'b1;
    at_limit   = count_next >= COUNT_W'(MAX_SAMPLES);
    closing    = last_sample || at_limit;
  end

  // Hand the closed packet to the queue
  always_comb begin
    push         = accept && closing;
    entry.sum    = sum_next;
    entry.count  = count_next;
    entry.forced = !last_sample && at_limit;
  end

  // Advance the running sum and count
  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      count <= '0;
    end else if (accept) begin
      if (closing) begin
        sum   <= '0;
        count <= '0;
      end else begin
        sum   <= sum_next;
        count <= count_next;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/vad_queue.sv
// ----------------------------------------------------------------------------
// Voice activity detector packet queue
// Short first-in first-out buffer of closed packets between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "voice_activity_detector_defines.svh"

module vad_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  vad_pkg::close_t        wr_entry,
  input  logic                   pop,
  output vad_pkg::close_t        rd_entry,
  output vad_pkg::queue_status_t status
);
  import vad_pkg::*;

  close_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   fill;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    rd_entry     = slots[rd_ptr];
    status.full  = fill == QCNT_W'(QUEUE_DEPTH);
    status.empty = fill == '0;
  end

  // Store the pushed packet
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  `VAD_ASSERT_NEVER(a_no_push_full, clk, rst, push && status.full, "push into full queue")
  `VAD_ASSERT_NEVER(a_no_pop_empty, clk, rst, pop && status.empty, "pop from empty queue")

endmodule

`default_nettype wire

### rtl/vad_back.sv
// ----------------------------------------------------------------------------
// Voice activity detector back end
// Divides each packet's sum by its count, updates runs and speaking state,
// and holds the result beat in an output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "voice_activity_detector_defines.svh"

module vad_back (
  input  logic                          clk,
  input  logic                          rst,
  input  vad_pkg::cfg_t                 cfg,
  input  vad_pkg::close_t               q_entry,
  input  vad_pkg::queue_status_t        q_status,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [vad_pkg::VOL_W-1:0]     volume,
  output logic                          speaking,
  output logic [vad_pkg::VOL_W-1:0]     peak_volume,
  output logic                          forced_end
);
  import vad_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_DONE
  } state_t;

  state_t              state;
  logic [SUM_W-1:0]    dvd;
  logic [COUNT_W-1:0]  divisor;
  logic [COUNT_W:0]    rem;
  logic [ITER_W-1:0]   iter;
  logic                forced;
  logic [RUN_W-1:0]    loud_run;
  logic [RUN_W-1:0]    quiet_run;
  logic [VOL_W-1:0]    max_volume;

  logic [COUNT_W:0]    rem_shift;
  logic                fits;
  logic [VOL_W-1:0]    vol;
  logic                loud;
  logic [RUN_W-1:0]    loud_next;
  logic [RUN_W-1:0]    quiet_next;
  logic                speaking_next;
  logic [VOL_W-1:0]    max_next;
  logic                slot_free;

  // One restoring division step; quotient bits shift into the dividend
  always_comb begin
    rem_shift = {rem[COUNT_W-1:0], dvd[SUM_W-1]};
    fits      = rem_shift >= {1'b0, divisor};
  end

  // Classify the finished volume and update runs and speaking state
  always_comb begin
    vol        = dvd[VOL_W-1:0];
    loud       = vol > cfg.threshold;
    loud_next  = loud ? run_bump(loud_run) : '0;
    quiet_next = loud ? '0 : run_bump(quiet_run);
    speaking_next = speaking;
    if (!speaking_next && (loud_next > cfg.speaking_run)) begin
      speaking_next = 1'b1;
    end
    if (speaking_next && (quiet_next > cfg.silence_run)) begin
      speaking_next = 1'b0;
    end
    max_next  = (vol > max_volume) ? vol : max_volume;
    slot_free = !out_valid || !out_stall;
    pop       = (state == ST_IDLE) && !q_status.empty;
  end

  // Sequence the divider and load the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      speaking    <= 1'b0;
      loud_run    <= '0;
      quiet_run   <= '0;
      max_volume  <= '0;
    end else begin
      // Drop an accepted beat unless a new one replaces it this cycle
      if (out_valid && !out_stall && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            dvd     <= q_entry.sum;
            divisor <= q_entry.count;
            forced  <= q_entry.forced;
            rem     <= '0;
            iter    <= ITER_W'(SUM_W - 1);
            state   <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          rem  <= fits ? (rem_shift - {1'b0, divisor}) : rem_shift;
          dvd  <= {dvd[SUM_W-2:0], fits};
          iter <= iter - 1'b1;
          if (iter == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            volume      <= vol;
            speaking    <= speaking_next;
            peak_volume <= max_next;
            forced_end  <= forced;
            out_valid   <= 1'b1;
            loud_run    <= loud_next;
            quiet_run   <= quiet_next;
            max_volume  <= max_next;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `VAD_ASSERT_IMPLIES(a_result_from_done, clk, rst, $rose(out_valid),
                      $past(state == ST_DONE), "result beat without finished division")
  `VAD_ASSERT_IMPLIES(a_quotient_fits, clk, rst, state == ST_DONE,
                      dvd[SUM_W-1:VOL_W] == '0, "quotient exceeds volume width")

endmodule

`default_nettype wire

### rtl/voice_activity_detector.sv
// ----------------------------------------------------------------------------
// Voice activity detector
// Energy-based voice activity detection on packets of signed PCM samples.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_stall    sample, last_sample
//   out      output     out_valid / out_stall  volume, speaking, peak_volume,
//                                              forced_end
//   cfg      input      cfg_write              cfg_index, cfg_data
//
// The front end takes one sample a cycle; it stalls only when the two-entry
// packet queue is full.
// The back end fetches each closed packet, runs it through the one-bit-a-cycle
// divider, then updates state and loads the result.
// A stalled result waits in the output register while the divider goes on.
// Synchronous reset clears control state but not data; config gets defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module voice_activity_detector (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [vad_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                 last_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [vad_pkg::VOL_W-1:0]            volume,
  output logic                                 speaking,
  output logic [vad_pkg::VOL_W-1:0]            peak_volume,
  output logic                                 forced_end,
  input  logic                                 cfg_write,
  input  logic [vad_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [vad_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import vad_pkg::*;

  cfg_t          cfg;
  close_t        push_entry;
  close_t        pop_entry;
  queue_status_t q_status;
  logic          push;
  logic          pop;

  // Hold configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold    <= THRESH_RESET;
      cfg.speaking_run <= SPEAKING_RESET;
      cfg.silence_run  <= SILENCE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_VOLUME_THRESHOLD: cfg.threshold    <= cfg_data[THRESH_W-1:0];
        REG_SPEAKING_RUN:     cfg.speaking_run <= cfg_data[RUN_W-1:0];
        REG_SILENCE_RUN:      cfg.silence_run  <= cfg_data[RUN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall = q_status.full;

  vad_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .q_full      (q_status.full),
    .sample      (sample),
    .last_sample (last_sample),
    .push        (push),
    .entry       (push_entry)
  );

  vad_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (push_entry),
    .pop      (pop),
    .rd_entry (pop_entry),
    .status   (q_status)
  );

  vad_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_entry     (pop_entry),
    .q_status    (q_status),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .volume      (volume),
    .speaking    (speaking),
    .peak_volume (peak_volume),
    .forced_end  (forced_end)
  );

endmodule

`default_nettype wire
